### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i and muted while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication outside reset
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

### hw/rtl/tttb_pkg.sv
// ----------------------------------------------------------------------------
// tttb_pkg
// types and constants shared by the task timer bank modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tttb_pkg;

  localparam int NumSlotsDef  = 8;
  localparam int TickWidthDef = 16;
  localparam int CmdW         = 3;
  localparam int IdxInW       = 3;
  localparam int ModeW        = 3;
  localparam int ReloadInW    = 16;
  localparam int PredW        = 4;
  localparam int FiredW       = 8;
  localparam int StatusW      = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_START   = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_PRED    = 3'd4
  } cmd_e;

  localparam logic [ModeW-1:0] MODE_CYCLIC     = 3'd0;
  localparam logic [ModeW-1:0] MODE_ONE_TIME   = 3'd1;
  localparam logic [ModeW-1:0] MODE_FOLLOW_CYC = 3'd2;
  localparam logic [ModeW-1:0] MODE_FOLLOW_ONE = 3'd3;
  localparam logic [ModeW-1:0] MODE_TRIGGERED  = 3'd4;

  typedef enum logic [StatusW-1:0] {
    RUN_RUNNING = 2'd0,
    RUN_WAITING = 2'd1,
    RUN_DONE    = 2'd2,
    RUN_EMPTY   = 2'd3
  } run_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_MODIFY = 5'b01000,
    ST_FINISH = 5'b10000
  } ctl_state_e;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic modify;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic out_free;
  } ctl_stat_t;

endpackage

### hw/rtl/tttb_ram.sv
// ----------------------------------------------------------------------------
// tttb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tttb_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/tttb_ctrl.sv
// ----------------------------------------------------------------------------
// tttb_ctrl
// sequencer: takes a command word, runs the slot scan or the single slot
// update, then hands the result to the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tttb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output tttb_pkg::ctl_cmd_t  cmd_o,
  input  tttb_pkg::ctl_stat_t stat_i
);
  import tttb_pkg::*;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        state_d = stat_i.is_tick ? ST_SCAN : ST_MODIFY;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_MODIFY: begin
        cmd_o.modify = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_IMPLIES(a_scan_only_tick, cmd_o.scan_step, stat_i.is_tick, "scan outside tick")
  `ASSERT_IMPLIES(a_modify_not_tick, cmd_o.modify, !stat_i.is_tick, "modify during tick")
  `ASSERT_ALWAYS(a_load_when_free, !cmd_o.load_out || stat_i.out_free, "output overrun")

endmodule

### hw/rtl/tttb_dpath.sv
// ----------------------------------------------------------------------------
// tttb_dpath
// slot record ram, run state and used flags, scan counter, fired mask and
// output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tttb_dpath #(
  parameter int NumSlots  = tttb_pkg::NumSlotsDef,
  parameter int TickWidth = tttb_pkg::TickWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tttb_pkg::ctl_cmd_t               cmd_i,
  output tttb_pkg::ctl_stat_t              stat_o,
  input  logic [tttb_pkg::CmdW-1:0]        command_i,
  input  logic [tttb_pkg::IdxInW-1:0]      slot_index_i,
  input  logic [tttb_pkg::ModeW-1:0]       task_mode_i,
  input  logic [tttb_pkg::ReloadInW-1:0]   reload_ticks_i,
  input  logic [tttb_pkg::IdxInW-1:0]      prior_slot_i,
  input  logic                             prior_enable_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [tttb_pkg::FiredW-1:0]      fired_mask_o,
  output logic [tttb_pkg::StatusW-1:0]     slot_status_o
);
  import tttb_pkg::*;

  localparam int IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int RecW = ModeW + 2 * TickWidth + PredW;

  // latched command word
  cmd_e                   cmd_q;
  logic [IdxInW-1:0]      idx_q;
  logic [ModeW-1:0]       mode_q;
  logic [TickWidth-1:0]   reload_q;
  logic [IdxInW-1:0]      prior_q;
  logic                   prior_en_q;

  logic [NumSlots-1:0]    used_q, used_d;
  run_e [NumSlots-1:0]    run_q, run_d;
  logic [IdxW-1:0]        scan_q, scan_d;
  logic [FiredW-1:0]      fired_q, fired_d;
  logic                   out_valid_q;

  logic [TickWidth+ReloadInW-1:0] reload_ext;
  logic [IdxW+IdxInW-1:0]         idx_ext;
  logic [IdxW-1:0]                idx_addr;
  logic                           idx_ok;
  logic                           scan_last;

  // ram
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  logic [RecW-1:0]      ram_wdata, ram_rdata;

  logic [ModeW-1:0]     rd_mode;
  logic [TickWidth-1:0] rd_reload, rd_cnt;
  logic [PredW-1:0]     rd_pred;

  // lookups
  logic                 scan_used;
  run_e                 scan_run;
  logic                 sel_used;
  run_e                 sel_run;
  run_e                 sel_status;
  run_e                 pred_status;

  // scan step
  logic                 follow, cyclic, blocked, step, fire;
  logic [TickWidth-1:0] scan_cnt;
  run_e                 scan_run_new;

  // single slot update
  logic                 mod_we;
  logic [RecW-1:0]      mod_rec;
  run_e                 mod_run;

  assign reload_ext = {{TickWidth{1'b0}}, reload_ticks_i};
  assign idx_ext    = {{IdxW{1'b0}}, idx_q};
  assign idx_addr   = idx_ext[IdxW-1:0];
  assign idx_ok     = ({{(32-IdxInW){1'b0}}, idx_q} < 32'(NumSlots));
  assign scan_last  = (scan_q == IdxW'(NumSlots - 1));

  assign rd_pred   = ram_rdata[PredW-1:0];
  assign rd_cnt    = ram_rdata[PredW+TickWidth-1:PredW];
  assign rd_reload = ram_rdata[PredW+2*TickWidth-1:PredW+TickWidth];
  assign rd_mode   = ram_rdata[RecW-1:PredW+2*TickWidth];

  // flag lookups by slot
  always_comb begin
    scan_used   = 1'b0;
    scan_run    = RUN_EMPTY;
    sel_used    = 1'b0;
    sel_run     = RUN_EMPTY;
    pred_status = RUN_EMPTY;
    for (int j = 0; j < NumSlots; j++) begin
      if (scan_q == IdxW'(j)) begin
        scan_used = used_q[j];
        scan_run  = run_q[j];
      end
      if (idx_ext == (IdxW+IdxInW)'(j)) begin
        sel_used = used_q[j];
        sel_run  = run_q[j];
      end
      if ({{IdxW{1'b0}}, rd_pred[IdxInW-1:0]} == (IdxW+IdxInW)'(j)) begin
        pred_status = used_q[j] ? run_q[j] : RUN_EMPTY;
      end
    end
    sel_status = (idx_ok && sel_used) ? sel_run : RUN_EMPTY;
  end

  // one slot of the tick scan
  always_comb begin
    follow  = (rd_mode == MODE_FOLLOW_CYC) || (rd_mode == MODE_FOLLOW_ONE);
    cyclic  = (rd_mode == MODE_CYCLIC) || (rd_mode == MODE_FOLLOW_CYC);
    blocked = follow && rd_pred[PredW-1] && (pred_status != RUN_DONE);
    step    = scan_used && (scan_run == RUN_RUNNING) && !blocked;
    fire    = step && (rd_cnt <= TickWidth'(1));
    if (fire) begin
      scan_cnt = cyclic ? rd_reload : rd_cnt;
      if (cyclic) begin
        scan_run_new = RUN_RUNNING;
      end else if (rd_mode == MODE_TRIGGERED) begin
        scan_run_new = RUN_WAITING;
      end else begin
        scan_run_new = RUN_DONE;
      end
    end else begin
      scan_cnt     = step ? (rd_cnt - TickWidth'(1)) : rd_cnt;
      scan_run_new = scan_run;
    end
  end

  // add, start, restart, define predecessor
  always_comb begin
    mod_we  = 1'b0;
    mod_rec = ram_rdata;
    mod_run = sel_run;
    case (cmd_q)
      CMD_ADD: begin
        mod_we  = idx_ok;
        mod_rec = {mode_q, reload_q, reload_q, {PredW{1'b0}}};
        mod_run = (mode_q == MODE_TRIGGERED) ? RUN_WAITING : RUN_RUNNING;
      end
      CMD_START: begin
        mod_we  = idx_ok && sel_used && (sel_run == RUN_WAITING);
        mod_rec = {rd_mode, rd_reload, rd_reload, rd_pred};
        mod_run = RUN_RUNNING;
      end
      CMD_RESTART: begin
        mod_we  = idx_ok && sel_used &&
                  ((sel_run == RUN_WAITING) || (sel_run == RUN_RUNNING));
        mod_rec = {rd_mode, rd_reload, rd_reload, rd_pred};
        mod_run = RUN_RUNNING;
      end
      CMD_PRED: begin
        mod_we  = idx_ok && sel_used;
        mod_rec = {rd_mode, rd_reload, rd_cnt,
                   prior_en_q ? {1'b1, prior_q} : {PredW{1'b0}}};
      end
      default: begin
        mod_we = 1'b0;
      end
    endcase
  end

  // ram ports
  always_comb begin
    ram_we    = cmd_i.scan_step || (cmd_i.modify && mod_we);
    ram_waddr = cmd_i.scan_step ? scan_q : idx_addr;
    ram_wdata = cmd_i.scan_step ? {rd_mode, rd_reload, scan_cnt, rd_pred} : mod_rec;
    if (cmd_i.scan_step) begin
      ram_raddr = scan_last ? '0 : (scan_q + IdxW'(1));
    end else if (cmd_q == CMD_TICK) begin
      ram_raddr = scan_q;
    end else begin
      ram_raddr = idx_addr;
    end
  end

  tttb_ram #(
    .Width (RecW),
    .Depth (NumSlots),
    .AddrW (IdxW)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // flag, counter and fired mask updates
  always_comb begin
    used_d  = used_q;
    run_d   = run_q;
    scan_d  = scan_q;
    fired_d = fired_q;
    if (cmd_i.capture) begin
      scan_d  = '0;
      fired_d = '0;
    end
    if (cmd_i.scan_step) begin
      scan_d = scan_last ? '0 : (scan_q + IdxW'(1));
    end
    for (int j = 0; j < NumSlots; j++) begin
      if (cmd_i.scan_step && (scan_q == IdxW'(j))) begin
        run_d[j] = scan_run_new;
      end
      if (cmd_i.modify && mod_we && (idx_addr == IdxW'(j))) begin
        used_d[j] = 1'b1;
        run_d[j]  = mod_run;
      end
    end
    for (int k = 0; k < FiredW; k++) begin
      if (cmd_i.scan_step && fire &&
          ({{IdxInW{1'b0}}, scan_q} == (IdxW+IdxInW)'(k))) begin
        fired_d[k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      run_q       <= {NumSlots{RUN_EMPTY}};
      scan_q      <= '0;
      fired_q     <= '0;
      cmd_q       <= CMD_TICK;
      out_valid_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      run_q   <= run_d;
      scan_q  <= scan_d;
      fired_q <= fired_d;
      if (cmd_i.capture) begin
        cmd_q <= cmd_e'(command_i);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q      <= slot_index_i;
      mode_q     <= task_mode_i;
      reload_q   <= reload_ext[TickWidth-1:0];
      prior_q    <= prior_slot_i;
      prior_en_q <= prior_enable_i;
    end
    if (cmd_i.load_out) begin
      fired_mask_o  <= fired_q;
      slot_status_o <= sel_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.is_tick   = (cmd_q == CMD_TICK);
  assign stat_o.scan_last = scan_last;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  `ASSERT_IMPLIES(a_fired_only_tick, cmd_q != CMD_TICK, fired_q == '0, "fired bits on non-tick")

endmodule

### hw/rtl/tick_task_timer_bank.sv
// ----------------------------------------------------------------------------
// tick_task_timer_bank
// a tick word visits the record ram one slot per cycle, in slot order; other
// commands read and update the single slot that slot_index_i names. a new
// command is taken only after the result is loaded into the output register.
// reset is asynchronous, active low: all slots empty, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_task_timer_bank #(
  parameter int NumSlots  = tttb_pkg::NumSlotsDef,
  parameter int TickWidth = tttb_pkg::TickWidthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tttb_pkg::CmdW-1:0]      command_i,
  input  logic [tttb_pkg::IdxInW-1:0]    slot_index_i,
  input  logic [tttb_pkg::ModeW-1:0]     task_mode_i,
  input  logic [tttb_pkg::ReloadInW-1:0] reload_ticks_i,
  input  logic [tttb_pkg::IdxInW-1:0]    prior_slot_i,
  input  logic                           prior_enable_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tttb_pkg::FiredW-1:0]    fired_mask_o,
  output logic [tttb_pkg::StatusW-1:0]   slot_status_o
);
  import tttb_pkg::*;

  ctl_cmd_t  ctl_cmd;
  ctl_stat_t ctl_stat;

  tttb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (ctl_cmd),
    .stat_i     (ctl_stat)
  );

  tttb_dpath #(
    .NumSlots  (NumSlots),
    .TickWidth (TickWidth)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctl_cmd),
    .stat_o         (ctl_stat),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .task_mode_i    (task_mode_i),
    .reload_ticks_i (reload_ticks_i),
    .prior_slot_i   (prior_slot_i),
    .prior_enable_i (prior_enable_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .fired_mask_o   (fired_mask_o),
    .slot_status_o  (slot_status_o)
  );

endmodule
